@@ src/bdt_pkg.sv @@
// Shared types and constants for the Bayer dither texel generator.
// No dependencies; used by every other file of the block.
package bdt_pkg;

    localparam int unsigned COL_W   = 7;
    localparam int unsigned ROW_W   = 7;
    localparam int unsigned LAYER_W = 6;
    localparam int unsigned RAMP_W  = 8;
    localparam int unsigned VALUE_W = 8;
    localparam int unsigned ADDR_W  = 20;
    localparam int unsigned RANK_W  = 6;
    localparam int unsigned M_W     = 14;  // (2b+1)(D-1) + 2*L*N^2 tops out at 16065
    localparam int unsigned PROD_W  = 22;  // 170*m + 5376 < 2^22
    localparam int unsigned Q_W     = 13;  // quotient before the final divide by 21

    // Single-dot pattern: depth term 1/4, rank term 1/4 -> round(127.5) = 128
    localparam logic [VALUE_W-1:0] VALUE_1X1 = 8'd128;

    // floor(q / 21) == (q * 3121) >> 16 for q < 13107
    localparam logic [11:0] DIV21_MUL   = 12'd3121;
    localparam int unsigned DIV21_SHIFT = 16;

    // Ramp rounding: round(num / 65025) == (2*num + 65025) / 130050
    localparam int unsigned RAMP_BIAS = 65025;
    localparam int unsigned RAMP_DEN2 = 130050;
    localparam int unsigned RAMP_N    = 256;

    typedef enum logic {
        OP_DITHER = 1'b0,
        OP_RAMP   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PAT_1X1 = 2'd0,
        PAT_2X2 = 2'd1,
        PAT_4X4 = 2'd2,
        PAT_8X8 = 2'd3
    } t_pat;

    // Control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    typedef logic [VALUE_W-1:0] t_ramp_lut [RAMP_N];

    // Smoothstep ramp, evaluated at elaboration only
    function automatic t_ramp_lut ramp_lut();
        t_ramp_lut    lut;
        longint unsigned num;
        for (int i = 0; i < RAMP_N; i++) begin
            num    = longint'(i) * longint'(i) * (765 - 2 * longint'(i));
            lut[i] = VALUE_W'((2 * num + RAMP_BIAS) / RAMP_DEN2);
        end
        return lut;
    endfunction

endpackage

@@ src/bdt_dither_value.sv @@
// Dither byte pipeline: rank/layer -> weighted sum -> scaled -> rounded byte.
// Three register stages. Depends on bdt_pkg.
module bdt_dither_value (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdt_pkg::t_ctl                 i_ctl,
    input  bdt_pkg::t_pat                 i_pat,
    input  logic [bdt_pkg::RANK_W-1:0]    i_rank,
    input  logic [bdt_pkg::LAYER_W-1:0]   i_layer,
    output bdt_pkg::t_ctl                 o_ctl,
    output logic [bdt_pkg::VALUE_W-1:0]   o_value
);

    // stage A: m = (2b+1)(D-1) + 2*L*N^2
    bdt_pkg::t_ctl                 r_a_ctl;
    bdt_pkg::t_pat                 r_a_pat;
    logic [bdt_pkg::M_W-1:0]       r_a_m;
    logic [bdt_pkg::M_W-1:0]       n_a_m;
    logic [bdt_pkg::M_W-1:0]       odd;
    logic [bdt_pkg::M_W-1:0]       lay;

    // stage B: rounded quotient, or the value before /21 for the 8x8 case
    bdt_pkg::t_ctl                 r_b_ctl;
    bdt_pkg::t_pat                 r_b_pat;
    logic [bdt_pkg::Q_W-1:0]       r_b_q;
    logic [bdt_pkg::Q_W-1:0]       n_b_q;
    logic [bdt_pkg::PROD_W-1:0]    m_ext;

    // stage C: final byte
    bdt_pkg::t_ctl                 r_c_ctl;
    logic [bdt_pkg::VALUE_W-1:0]   r_c_value;
    logic [bdt_pkg::VALUE_W-1:0]   n_c_value;
    logic [bdt_pkg::Q_W+11:0]      div_prod;

    always_comb begin
        odd = bdt_pkg::M_W'({i_rank, 1'b1});
        lay = bdt_pkg::M_W'(i_layer);
        unique case (i_pat)
            bdt_pkg::PAT_2X2: n_a_m = (odd << 2) - odd + (lay << 3);
            bdt_pkg::PAT_4X4: n_a_m = (odd << 4) - odd + (lay << 5);
            bdt_pkg::PAT_8X8: n_a_m = (odd << 6) - odd + (lay << 7);
            default:          n_a_m = '0;  // 1x1 is a constant
        endcase
    end

    // 255/48 = 85/16, 255/960 = 17/64, 255/16128 = 85/(256*21)
    always_comb begin
        m_ext = bdt_pkg::PROD_W'(r_a_m);
        unique case (r_a_pat)
            bdt_pkg::PAT_2X2: n_b_q = bdt_pkg::Q_W'((m_ext * 22'd170 + 22'd16) >> 5);
            bdt_pkg::PAT_4X4: n_b_q = bdt_pkg::Q_W'((m_ext * 22'd34 + 22'd64) >> 7);
            bdt_pkg::PAT_8X8: n_b_q = bdt_pkg::Q_W'((m_ext * 22'd170 + 22'd5376) >> 9);
            default:          n_b_q = '0;
        endcase
    end

    always_comb begin
        div_prod = (bdt_pkg::Q_W+12)'(r_b_q) * (bdt_pkg::Q_W+12)'(bdt_pkg::DIV21_MUL);
        unique case (r_b_pat)
            bdt_pkg::PAT_1X1: n_c_value = bdt_pkg::VALUE_1X1;
            bdt_pkg::PAT_8X8: n_c_value =
                div_prod[bdt_pkg::DIV21_SHIFT +: bdt_pkg::VALUE_W];
            default:          n_c_value = r_b_q[bdt_pkg::VALUE_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
            r_c_ctl <= r_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pat   <= i_pat;
        r_a_m     <= n_a_m;
        r_b_pat   <= r_a_pat;
        r_b_q     <= n_b_q;
        r_c_value <= n_c_value;
    end

    assign o_ctl   = r_c_ctl;
    assign o_value = r_c_value;

endmodule

@@ src/bayer_dither_texel_generator.sv @@
// Top level of the Bayer dither texel generator: decode, address, ramp table.
// Depends on bdt_pkg and bdt_dither_value.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  request   | start / busy         | i_op i_pattern i_col i_row i_layer i_ramp_index
//  result    | o_valid (strobe)     | o_texel_value o_texel_address
//
// One transfer per clock: each request taken passes the four-stage pipeline
// and shows its result with o_valid high.
// busy never rises; the pipeline has no stall path and the receiver must
// take each result in the cycle it is strobed.
// Synchronous active-low reset clears only the control bits (valid and op);
// payload registers are not reset.
//
// Stage 1 (this file): clamp col/row/layer to the pattern, form the Bayer
//   rank from the coordinate bits, the linear address, and the ramp byte
//   from a constant 256-entry table.
// Stages 2-4 (bdt_dither_value): weighted sum, constant scale, final /21 for 8x8.
module bayer_dither_texel_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [1:0]                    i_pattern,
    input  logic [bdt_pkg::COL_W-1:0]     i_col,
    input  logic [bdt_pkg::ROW_W-1:0]     i_row,
    input  logic [bdt_pkg::LAYER_W-1:0]   i_layer,
    input  logic [bdt_pkg::RAMP_W-1:0]    i_ramp_index,
    output logic                          o_valid,
    output logic [bdt_pkg::VALUE_W-1:0]   o_texel_value,
    output logic [bdt_pkg::ADDR_W-1:0]    o_texel_address
);

    localparam bdt_pkg::t_ramp_lut RampLut = bdt_pkg::ramp_lut();
    localparam int unsigned        TailDly = 3;  // stages inside bdt_dither_value

    logic                          accept;
    bdt_pkg::t_pat                 pat;
    bdt_pkg::t_op                  op;
    logic [bdt_pkg::COL_W-1:0]     col_max;
    logic [bdt_pkg::LAYER_W-1:0]   layer_max;
    logic [bdt_pkg::COL_W-1:0]     col_s;
    logic [bdt_pkg::ROW_W-1:0]     row_s;
    logic [bdt_pkg::LAYER_W-1:0]   layer_s;
    logic [bdt_pkg::RANK_W-1:0]    rank;
    logic [bdt_pkg::ADDR_W-1:0]    n_addr;

    bdt_pkg::t_ctl                 r_s1_ctl;
    bdt_pkg::t_ctl                 n_s1_ctl;
    bdt_pkg::t_pat                 r_s1_pat;
    logic [bdt_pkg::RANK_W-1:0]    r_s1_rank;
    logic [bdt_pkg::LAYER_W-1:0]   r_s1_layer;

    // address and ramp byte ride alongside the dither tail
    logic [bdt_pkg::ADDR_W-1:0]    r_addr_dly [TailDly+1];
    logic [bdt_pkg::VALUE_W-1:0]   r_ramp_dly [TailDly+1];

    bdt_pkg::t_ctl                 tail_ctl;
    logic [bdt_pkg::VALUE_W-1:0]   tail_value;

    // quadrant digit: (0,0)=0 (1,0)=2 (0,1)=3 (1,1)=1
    function automatic logic [1:0] bayer_digit(input logic xb, input logic yb);
        return yb ? (xb ? 2'd1 : 2'd3) : (xb ? 2'd2 : 2'd0);
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pat    = bdt_pkg::t_pat'(i_pattern);
    assign op     = bdt_pkg::t_op'(i_op);

    always_comb begin
        unique case (pat)
            bdt_pkg::PAT_1X1: begin col_max = 7'd15;  layer_max = 6'd0;  end
            bdt_pkg::PAT_2X2: begin col_max = 7'd31;  layer_max = 6'd3;  end
            bdt_pkg::PAT_4X4: begin col_max = 7'd63;  layer_max = 6'd15; end
            default:          begin col_max = 7'd127; layer_max = 6'd63; end
        endcase
        col_s   = (i_col > col_max) ? col_max : i_col;
        row_s   = (i_row > col_max) ? col_max : i_row;
        layer_s = (i_layer > layer_max) ? layer_max : i_layer;
    end

    // bit 0 gives the most significant digit
    always_comb begin
        rank = '0;
        for (int k = 0; k < 3; k++) begin
            if (k < int'(i_pattern)) begin
                rank = {rank[bdt_pkg::RANK_W-3:0], bayer_digit(col_s[k], row_s[k])};
            end
        end
    end

    // width is a power of two and coordinates are clamped, so fields pack
    always_comb begin
        if (op == bdt_pkg::OP_RAMP) begin
            n_addr = bdt_pkg::ADDR_W'(i_ramp_index);
        end else begin
            unique case (pat)
                bdt_pkg::PAT_1X1: n_addr = bdt_pkg::ADDR_W'({row_s[3:0], col_s[3:0]});
                bdt_pkg::PAT_2X2: n_addr = bdt_pkg::ADDR_W'({layer_s[1:0], row_s[4:0],
                                                             col_s[4:0]});
                bdt_pkg::PAT_4X4: n_addr = bdt_pkg::ADDR_W'({layer_s[3:0], row_s[5:0],
                                                             col_s[5:0]});
                default:          n_addr = {layer_s, row_s, col_s};
            endcase
        end
    end

    always_comb begin
        n_s1_ctl.valid = accept;
        n_s1_ctl.op    = op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pat      <= pat;
        r_s1_rank     <= rank;
        r_s1_layer    <= layer_s;
        r_addr_dly[0] <= n_addr;
        r_ramp_dly[0] <= RampLut[i_ramp_index];
        for (int s = 1; s <= TailDly; s++) begin
            r_addr_dly[s] <= r_addr_dly[s-1];
            r_ramp_dly[s] <= r_ramp_dly[s-1];
        end
    end

    bdt_dither_value u_dither_value (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_pat   (r_s1_pat),
        .i_rank  (r_s1_rank),
        .i_layer (r_s1_layer),
        .o_ctl   (tail_ctl),
        .o_value (tail_value)
    );

    assign o_valid         = tail_ctl.valid;
    assign o_texel_value   = (tail_ctl.op == bdt_pkg::OP_RAMP) ? r_ramp_dly[TailDly]
                                                                : tail_value;
    assign o_texel_address = r_addr_dly[TailDly];

endmodule

@@ src/bdt_checker.sv @@
// Port-level checks for the Bayer dither texel generator, bound to the top.
// Depends on bdt_pkg and bayer_dither_texel_generator.
module bdt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_op,
    input logic [1:0]                    i_pattern,
    input logic [bdt_pkg::COL_W-1:0]     i_col,
    input logic [bdt_pkg::ROW_W-1:0]     i_row,
    input logic [bdt_pkg::LAYER_W-1:0]   i_layer,
    input logic [bdt_pkg::RAMP_W-1:0]    i_ramp_index,
    input logic                          o_valid,
    input logic [bdt_pkg::VALUE_W-1:0]   o_texel_value,
    input logic [bdt_pkg::ADDR_W-1:0]    o_texel_address
);

    logic taken;
    assign taken = start && !busy;

    // every transfer comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        taken |-> ##4 o_valid)
        else $error("result strobe missing four cycles after a transfer");

    // no result without a matching transfer
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(taken, 4))
        else $error("result strobe without a transfer");

    // ramp results carry the index as their address
    a_ramp_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(taken && i_op == bdt_pkg::OP_RAMP, 4)
        |-> o_texel_address == bdt_pkg::ADDR_W'($past(i_ramp_index, 4)))
        else $error("ramp address differs from ramp index");

    // single-dot pattern: constant mid value, 16x16 single-layer texture
    a_dot_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(taken && i_op == bdt_pkg::OP_DITHER &&
                         i_pattern == bdt_pkg::PAT_1X1, 4)
        |-> o_texel_value == bdt_pkg::VALUE_1X1 && o_texel_address < 20'd256)
        else $error("1x1 pattern result out of line");

    // 8x8 pattern never clamps: the address is the packed coordinates
    a_full_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(taken && i_op == bdt_pkg::OP_DITHER &&
                         i_pattern == bdt_pkg::PAT_8X8, 4)
        |-> o_texel_address == {$past(i_layer, 4), $past(i_row, 4), $past(i_col, 4)})
        else $error("8x8 address differs from packed coordinates");

endmodule

bind bayer_dither_texel_generator bdt_checker u_bdt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_op            (i_op),
    .i_pattern       (i_pattern),
    .i_col           (i_col),
    .i_row           (i_row),
    .i_layer         (i_layer),
    .i_ramp_index    (i_ramp_index),
    .o_valid         (o_valid),
    .o_texel_value   (o_texel_value),
    .o_texel_address (o_texel_address)
);

@@ tb/sv/bayer_dither_texel_checker.sv @@
// Scoreboard for the Bayer dither texel generator: watches request and result
// transfers, predicts each texel byte and address, and counts mismatches.
// Depends on bdt_pkg for widths and the op encoding.
module bayer_dither_texel_checker
    import bdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic                 i_op,
    input  logic [1:0]           i_pattern,
    input  logic [COL_W-1:0]     i_col,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [LAYER_W-1:0]   i_layer,
    input  logic [RAMP_W-1:0]    i_ramp_index,
    input  logic                 i_valid,
    input  logic [VALUE_W-1:0]   i_texel_value,
    input  logic [ADDR_W-1:0]    i_texel_address,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ADDR_W-1:0]  address;
    } texel_t;

    texel_t expected_texels[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned round_half_up(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic texel_t texel_expected(
        logic               op_bit,
        logic [1:0]         pat,
        logic [COL_W-1:0]   c,
        logic [ROW_W-1:0]   r,
        logic [LAYER_W-1:0] l,
        logic [RAMP_W-1:0]  ri
    );
        texel_t      t;
        int unsigned n, w, d, nn, cc, rr, ll, x, y, rank, num, den, idx;
        if (t_op'(op_bit) == OP_RAMP) begin
            idx       = ri;
            num       = idx * idx * (765 - 2 * idx);
            t.value   = VALUE_W'(round_half_up(num, 65025));
            t.address = ADDR_W'(idx);
            return t;
        end
        n  = 1 << pat;
        w  = 16 << pat;
        d  = 1 << (2 * pat);
        nn = n * n;
        cc = (c > w - 1) ? w - 1 : c;
        rr = (r > w - 1) ? w - 1 : r;
        ll = (l > d - 1) ? d - 1 : l;
        x  = cc & (n - 1);
        y  = rr & (n - 1);
        // bit 0 of the coordinates gives the most significant base-4 digit
        rank = 0;
        for (int k = 0; k < pat; k++) begin
            rank = rank * 4 + (((y >> k) & 1) ? (((x >> k) & 1) ? 1 : 3)
                                              : (((x >> k) & 1) ? 2 : 0));
        end
        if (d > 1) begin
            den = 4 * nn * (d - 1);
            num = 255 * ((2 * rank + 1) * (d - 1) + 2 * ll * nn);
        end else begin
            // single layer: depth term is a flat 1/4
            den = 4 * nn;
            num = 255 * (2 * rank + 1 + nn);
        end
        t.value   = VALUE_W'(round_half_up(num, den));
        t.address = ADDR_W'(ll * w * w + rr * w + cc);
        return t;
    endfunction

    task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
        $display("[%0t] texel mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_v,
                 got_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        texel_t want;
        if (i_rst_n) begin
            if (i_valid === 1'b1) begin
                if (expected_texels.size() == 0) begin
                    report_mismatch("unexpected result", 0, {i_texel_value, i_texel_address});
                end else begin
                    want = expected_texels.pop_front();
                    if (i_texel_value !== want.value)
                        report_mismatch("texel_value", want.value, i_texel_value);
                    if (i_texel_address !== want.address)
                        report_mismatch("texel_address", want.address, i_texel_address);
                end
            end
            if (i_start && !i_busy)
                expected_texels.push_back(texel_expected(i_op, i_pattern, i_col, i_row,
                                                         i_layer, i_ramp_index));
        end
        o_pending = expected_texels.size();
    end

endmodule

@@ tb/sv/bayer_dither_texel_generator_tb.sv @@
// Testbench top for the Bayer dither texel generator: clock, reset, request
// stimulus and verdict. Depends on bdt_pkg, the DUT and bayer_dither_texel_checker.
module bayer_dither_texel_generator_tb;
    import bdt_pkg::*;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    logic               op         = 1'b0;
    logic [1:0]         pattern    = '0;
    logic [COL_W-1:0]   col        = '0;
    logic [ROW_W-1:0]   row        = '0;
    logic [LAYER_W-1:0] layer      = '0;
    logic [RAMP_W-1:0]  ramp_index = '0;
    logic               res_valid;
    logic [VALUE_W-1:0] res_value;
    logic [ADDR_W-1:0]  res_address;
    int                 fail_count;
    int                 pending;

    // percentage of cycles the request side holds start low between transfers
    int unsigned        idle_pct = 0;

    bayer_dither_texel_generator uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (op),
        .i_pattern       (pattern),
        .i_col           (col),
        .i_row           (row),
        .i_layer         (layer),
        .i_ramp_index    (ramp_index),
        .o_valid         (res_valid),
        .o_texel_value   (res_value),
        .o_texel_address (res_address)
    );

    bayer_dither_texel_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (op),
        .i_pattern       (pattern),
        .i_col           (col),
        .i_row           (row),
        .i_layer         (layer),
        .i_ramp_index    (ramp_index),
        .i_valid         (res_valid),
        .i_texel_value   (res_value),
        .i_texel_address (res_address),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Hard stop; a healthy run finishes in a small fraction of this.
    initial begin
        #400000;
        $display("bayer_dither_texel_generator regression: fail");
        $finish;
    end

    // One request transfer. Optional idle cycles first, then the payload is
    // driven with start high until an edge sees busy low. start is left high
    // so back-to-back transfers need no extra assignment in the same step.
    task automatic send_request(
        input logic               op_v,
        input logic [1:0]         pat_v,
        input logic [COL_W-1:0]   col_v,
        input logic [ROW_W-1:0]   row_v,
        input logic [LAYER_W-1:0] layer_v,
        input logic [RAMP_W-1:0]  ramp_v
    );
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        op         <= op_v;
        pattern    <= pat_v;
        col        <= col_v;
        row        <= row_v;
        layer      <= layer_v;
        ramp_index <= ramp_v;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    // Random request: half dither, half ramp. Coordinates mostly stay inside
    // the pattern, the rest roam the full field to hit saturation. Unused
    // fields always carry noise.
    task automatic send_random();
        logic [1:0]  pat_v;
        int unsigned w, d;
        pat_v = 2'($urandom_range(3));
        w     = 16 << pat_v;
        d     = 1 << (2 * pat_v);
        send_request(
            $urandom_range(1) ? OP_RAMP : OP_DITHER,
            pat_v,
            COL_W'(($urandom_range(3) != 0) ? $urandom_range(w - 1) : $urandom_range(127)),
            ROW_W'(($urandom_range(3) != 0) ? $urandom_range(w - 1) : $urandom_range(127)),
            LAYER_W'(($urandom_range(3) != 0) ? $urandom_range(d - 1) : $urandom_range(63)),
            RAMP_W'($urandom_range(255)));
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part, sent back to back ---
        // every pattern at the origin and at the far corner
        send_request(OP_DITHER, PAT_1X1, 0, 0, 0, 0);
        send_request(OP_DITHER, PAT_2X2, 0, 0, 0, 0);
        send_request(OP_DITHER, PAT_4X4, 0, 0, 0, 0);
        send_request(OP_DITHER, PAT_8X8, 0, 0, 0, 0);
        send_request(OP_DITHER, PAT_1X1, 127, 127, 63, 255);
        send_request(OP_DITHER, PAT_2X2, 127, 127, 63, 255);
        send_request(OP_DITHER, PAT_4X4, 127, 127, 63, 255);
        send_request(OP_DITHER, PAT_8X8, 127, 127, 63, 255);
        // last in-range coordinate vs one past it (saturation edge)
        send_request(OP_DITHER, PAT_1X1, 15, 15, 0, 0);
        send_request(OP_DITHER, PAT_1X1, 16, 16, 1, 0);
        send_request(OP_DITHER, PAT_2X2, 31, 32, 3, 0);
        send_request(OP_DITHER, PAT_2X2, 32, 31, 4, 0);
        send_request(OP_DITHER, PAT_4X4, 63, 64, 15, 0);
        send_request(OP_DITHER, PAT_4X4, 64, 63, 16, 0);
        // rank digits: col bit 0 alone, row bit 2 alone, then a mix of bits
        send_request(OP_DITHER, PAT_8X8, 1, 0, 5, 0);
        send_request(OP_DITHER, PAT_8X8, 0, 4, 62, 0);
        send_request(OP_DITHER, PAT_8X8, 5, 6, 31, 0);
        // ramp ends and middle, with junk on the dither fields
        send_request(OP_RAMP, PAT_8X8, 127, 127, 63, 0);
        send_request(OP_RAMP, PAT_1X1, 85, 42, 21, 1);
        send_request(OP_RAMP, PAT_2X2, 0, 0, 0, 127);
        send_request(OP_RAMP, PAT_4X4, 127, 0, 63, 128);
        send_request(OP_RAMP, PAT_8X8, 0, 127, 0, 254);
        send_request(OP_RAMP, PAT_1X1, 127, 127, 63, 255);

        // --- random part in three idle regimes ---
        idle_pct = 20;
        repeat (300) send_random();
        idle_pct = 84;
        repeat (300) send_random();
        idle_pct = 0;
        repeat (300) send_random();

        // let the checker log the last transfer, then drain the pipeline
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("bayer_dither_texel_generator regression: pass");
        end else begin
            $display("bayer_dither_texel_generator regression: fail");
        end
        $finish;
    end

endmodule
